/* rtl/gfsd_pkg.sv */
package gfsd_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned TS_W       = 32;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned SPF_W      = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned M_TDATA_W  = 48;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SIGNATURE_NIBBLE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLES_PER_FRAME = 2'd1;

    // Register reset values
    localparam logic [NIBBLE_W-1:0] SIGNATURE_RESET = 4'hD;
    localparam logic [SPF_W-1:0]    SPF_RESET       = 16'd160;

    // Frame alignment phase
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_CHECK   = 2'd2
    } phase_t;

    // Sequencer state
    typedef enum logic {
        CTL_IDLE  = 1'b0,
        CTL_DRAIN = 1'b1
    } ctl_state_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [NIBBLE_W-1:0] signature_nibble;
        logic [SPF_W-1:0]    samples_per_frame;
    } cfg_t;

    // One result item, without its last flag
    typedef struct packed {
        logic [TS_W-1:0]   frame_timestamp;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] frame_byte;
    } out_item_t;

endpackage

/* rtl/gsm_frame_sync_deframer_core.sv */
// GSM full-rate frame synchronizer and deframer. Raw stream bytes enter on the
// s_ side one item per cycle while no frame is being released; a byte that
// completes a frame in sync, or that confirms sync after a held frame, starts
// a read-out of FRAME_BYTES result items from the single-read-port frame
// buffer, one per cycle while m_tready does not stall, and s_tready stays
// low until the last item is loaded into the output register. Every result
// of a frame carries the same timestamp, which advances by samples_per_frame
// after the frame. Configuration writes are taken in one cycle and should
// come only while the block is idle.
module gsm_frame_sync_deframer_core #(
    parameter int unsigned FRAME_BYTES = 33
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gfsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gfsd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gfsd_pkg::BYTE_W-1:0]        s_tdata,  // [7:0] data_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] frame_byte, [13:8] byte_index, [45:14] frame_timestamp, [47:46] zero
    output logic [gfsd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    import gfsd_pkg::*;

    localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);

    logic [NIBBLE_W-1:0] sig_nibble_reg;
    logic [SPF_W-1:0]    spf_reg;
    cfg_t                cfg;
    out_item_t           out_item;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_nibble_reg <= SIGNATURE_RESET;
            spf_reg        <= SPF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SIGNATURE_NIBBLE:  sig_nibble_reg <= cfg_wdata[NIBBLE_W-1:0];
                REG_SAMPLES_PER_FRAME: spf_reg        <= cfg_wdata[SPF_W-1:0];
                default:               ;
            endcase
        end
    end

    assign cfg.signature_nibble  = sig_nibble_reg;
    assign cfg.samples_per_frame = spf_reg;

    // Frame buffer
    gfsd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Alignment and read-out sequencer
    gfsd_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (m_tvalid),
        .m_tready  (m_tready),
        .out_item  (out_item),
        .out_last  (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Pack the result item
    assign m_tdata = {{(M_TDATA_W - TS_W - IDX_W - BYTE_W){1'b0}}, out_item};

endmodule

/* rtl/gfsd_ram.sv */
module gfsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/gfsd_ctrl.sv */
module gfsd_ctrl #(
    parameter int unsigned FRAME_BYTES = 33
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gfsd_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gfsd_pkg::BYTE_W-1:0]    s_tdata,
    output logic                           out_valid,
    input  logic                           m_tready,
    output gfsd_pkg::out_item_t            out_item,
    output logic                           out_last,
    output logic                           ram_we,
    output logic [$clog2(FRAME_BYTES)-1:0] ram_waddr,
    output logic [gfsd_pkg::BYTE_W-1:0]    ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(FRAME_BYTES)-1:0] ram_raddr,
    input  logic [gfsd_pkg::BYTE_W-1:0]    ram_rdata
);

    import gfsd_pkg::*;

    localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
    localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0]  FRAME_CNT = CNT_W'(FRAME_BYTES);
    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(FRAME_BYTES - 1);

    ctl_state_t        ctl_state_reg, ctl_state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              in_sync_reg, in_sync_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              start_pend_reg, start_pend_next;
    logic [BYTE_W-1:0] start_byte_reg, start_byte_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              sig_match;
    logic              out_free;
    logic              load;
    logic [CNT_W-1:0]  cnt_inc;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_state_reg  <= CTL_IDLE;
            phase_reg      <= PH_HUNT;
            cnt_reg        <= '0;
            in_sync_reg    <= 1'b0;
            ts_reg         <= '0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            start_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctl_state_reg  <= ctl_state_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            in_sync_reg    <= in_sync_next;
            ts_reg         <= ts_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_reg       <= pend_next;
            start_pend_reg <= start_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        start_byte_reg <= start_byte_next;
        out_item_reg   <= out_item_next;
        out_last_reg   <= out_last_next;
    end

    assign s_tready  = (ctl_state_reg == CTL_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign sig_match = (s_tdata[BYTE_W-1 -: NIBBLE_W] == cfg.signature_nibble);
    assign out_free  = !out_valid_reg || m_tready;
    assign load      = (ctl_state_reg == CTL_DRAIN) && pend_reg && out_free;
    assign cnt_inc   = cnt_reg + 1'b1;

    // Sequencer: frame alignment on accepted items, read-out of released frames
    always_comb
    begin
        ctl_state_next  = ctl_state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        in_sync_next    = in_sync_reg;
        ts_next         = ts_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        start_pend_next = start_pend_reg;
        start_byte_next = start_byte_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = s_tdata;
        ram_re          = 1'b0;
        ram_raddr       = rd_cnt_reg[ADDR_W-1:0];

        // Drop the output item once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctl_state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_COLLECT:
                        begin
                            // Store the byte; on a full frame release or check
                            if (cnt_reg < FRAME_CNT)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[ADDR_W-1:0];
                            end
                            cnt_next = cnt_inc;
                            if (cnt_inc >= FRAME_CNT)
                            begin
                                cnt_next = '0;
                                if (in_sync_reg)
                                begin
                                    phase_next      = PH_HUNT;
                                    ctl_state_next  = CTL_DRAIN;
                                    rd_cnt_next     = '0;
                                    pend_next       = 1'b0;
                                    start_pend_next = 1'b0;
                                end
                                else
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                        end
                        PH_CHECK:
                        begin
                            // Confirm sync and hold the byte until read-out ends; on a mismatch hunt again
                            if (sig_match)
                            begin
                                in_sync_next    = 1'b1;
                                ctl_state_next  = CTL_DRAIN;
                                rd_cnt_next     = '0;
                                pend_next       = 1'b0;
                                start_pend_next = 1'b1;
                                start_byte_next = s_tdata;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                                cnt_next   = '0;
                            end
                        end
                        default:
                        begin
                            // Hunt for a frame start; a mismatch drops sync
                            if (sig_match)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                cnt_next   = CNT_W'(1);
                                phase_next = PH_COLLECT;
                            end
                            else
                            begin
                                in_sync_next = 1'b0;
                                phase_next   = PH_HUNT;
                                cnt_next     = '0;
                            end
                        end
                    endcase
                end
            end
            CTL_DRAIN:
            begin
                // Move read data into the output register
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_item_next.frame_byte      = ram_rdata;
                    out_item_next.byte_index      = IDX_W'(pend_idx_reg);
                    out_item_next.frame_timestamp = ts_reg;
                    out_last_next  = (pend_idx_reg == LAST_IDX);
                    pend_next      = 1'b0;
                end
                // Issue the next read when its data has a place to go
                if ((rd_cnt_reg < FRAME_CNT) && (!pend_reg || load))
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[ADDR_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                // Finish: advance the timestamp, go idle, start a new frame with any held byte
                if (load && (pend_idx_reg == LAST_IDX))
                begin
                    ctl_state_next = CTL_IDLE;
                    ts_next = ts_reg + {{(TS_W - SPF_W){1'b0}}, cfg.samples_per_frame};
                    if (start_pend_reg)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = '0;
                        ram_wdata       = start_byte_reg;
                        phase_next      = PH_COLLECT;
                        cnt_next        = CNT_W'(1);
                        start_pend_next = 1'b0;
                    end
                end
            end
            default:
            begin
                ctl_state_next = CTL_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_last  = out_last_reg;

endmodule
